// File: design/sync_frame_receiver_macros.svh
// Assertion macros for the sync frame receiver.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef SYNC_FRAME_RECEIVER_MACROS_SVH
`define SYNC_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFR_CHECK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFR_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sfr_pkg.sv
// Shared types, constants and the microcode program of the sync frame receiver.
// Used by sfr_useq, sfr_datapath and sync_frame_receiver; depends on nothing.
package sfr_pkg;

	localparam int N_SLOTS_DEF = 6;
	localparam int WORD_W      = 16;
	localparam int DUTY_W      = 15;
	localparam int DEPTH_W     = 4;
	localparam int PEND_W      = 8;
	localparam int ERR_W       = 16;
	localparam int STAT_W      = 2;
	localparam int STEP_W      = 4;
	localparam int START_BIT   = 15;

	localparam logic [PEND_W-1:0] MAX_DEPTH = 8'd15;

	typedef enum logic [STAT_W-1:0] {
		STAT_SLOT     = 2'd0,
		STAT_NOSYNC   = 2'd1,
		STAT_MISMATCH = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_STORE,
		OP_START,
		OP_ERR_SYNC,
		OP_ERR_SUM,
		OP_FRAME_END,
		OP_SLOT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_START,
		C_NOSYNC,
		C_POS_FULL,
		C_SUM_OK,
		C_MORE
	} cond_t;

	typedef enum logic [STEP_W-1:0] {
		ST_FETCH      = 4'd0,
		ST_TEST_START = 4'd1,
		ST_TEST_SYNC  = 4'd2,
		ST_TEST_POS   = 4'd3,
		ST_STORE      = 4'd4,
		ST_START      = 4'd5,
		ST_NOSYNC     = 4'd6,
		ST_CHECK      = 4'd7,
		ST_MISMATCH   = 4'd8,
		ST_EMIT       = 4'd9,
		ST_SLOT       = 4'd10,
		ST_DONE       = 4'd11
	} step_t;

	// One microinstruction: hold conditions, datapath action, branch.
	typedef struct packed {
		logic  wait_in;
		logic  wait_out;
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} dp_ctl_t;

	typedef struct packed {
		logic start;
		logic synced;
		logic pos_full;
		logic sum_ok;
		logic more;
		logic out_free;
	} dp_flags_t;

	// Control store. A taken branch goes to target, otherwise to the next step.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{wait_in: 1'b0, wait_out: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: ST_FETCH};
		case (s)
			ST_FETCH: begin
				w.wait_in = 1'b1;
				w.op      = OP_LATCH;
				w.cond    = C_NEVER;
			end
			ST_TEST_START: begin
				w.cond   = C_START;
				w.target = ST_START;
			end
			ST_TEST_SYNC: begin
				w.cond   = C_NOSYNC;
				w.target = ST_NOSYNC;
			end
			ST_TEST_POS: begin
				w.cond   = C_POS_FULL;
				w.target = ST_CHECK;
			end
			ST_STORE:  w.op = OP_STORE;
			ST_START:  w.op = OP_START;
			ST_NOSYNC: begin
				w.wait_out = 1'b1;
				w.op       = OP_ERR_SYNC;
			end
			ST_CHECK: begin
				w.cond   = C_SUM_OK;
				w.target = ST_EMIT;
			end
			ST_MISMATCH: begin
				w.wait_out = 1'b1;
				w.op       = OP_ERR_SUM;
			end
			ST_EMIT: begin
				w.op   = OP_FRAME_END;
				w.cond = C_NEVER;
			end
			ST_SLOT: begin
				w.wait_out = 1'b1;
				w.op       = OP_SLOT;
				w.cond     = C_MORE;
				w.target   = ST_SLOT;
			end
			ST_DONE:   w.cond = C_ALWAYS;
			default:   w.cond = C_ALWAYS;
		endcase
		return w;
	endfunction

endpackage

// File: design/sync_frame_receiver.sv
// Sync frame receiver top level: microcode sequencer plus datapath.
// Depends on sfr_pkg, sfr_useq, sfr_datapath and sync_frame_receiver_macros.svh.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_stall   | link_word
//   out     | out_valid / out_stall | status slot duty depth depth_valid
//           |                       | error_count last
//
// Each input transaction (start word, data word, word before sync, checksum
// mismatch or match) runs one path of the microcode program, one step per cycle
// except while a step waits for an input word or for a free output register.
// Reset (arst_n low) clears the step counter and all frame and error state.
// A stalled sink holds the output register; the sequencer waits only in
// steps that load that register, and keeps taking words otherwise.
`include "sync_frame_receiver_macros.svh"

module sync_frame_receiver #(
	parameter int N_SLOTS = sfr_pkg::N_SLOTS_DEF,
	localparam int SLOT_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sfr_pkg::WORD_W-1:0]  link_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sfr_pkg::STAT_W-1:0]  status,
	output logic [SLOT_W-1:0]           slot,
	output logic [sfr_pkg::DUTY_W-1:0]  duty,
	output logic [sfr_pkg::DEPTH_W-1:0] depth,
	output logic                        depth_valid,
	output logic [sfr_pkg::ERR_W-1:0]   error_count,
	output logic                        last
);

	// control word toward the datapath, condition flags back
	sfr_pkg::dp_ctl_t   ctl;
	sfr_pkg::dp_flags_t flags;

	sfr_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.ctl      (ctl)
	);

	// frame registers, slot store and the output register
	sfr_datapath #(
		.N_SLOTS (N_SLOTS),
		.SLOT_W  (SLOT_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.flags       (flags),
		.link_word   (link_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot        (slot),
		.duty        (duty),
		.depth       (depth),
		.depth_valid (depth_valid),
		.error_count (error_count),
		.last        (last)
	);

	// error results are always single transactions
	`SFR_CHECK_IMPLY(a_err_single, out_valid && status != sfr_pkg::STAT_SLOT, last, "error without last")
	// a depth above the limit shows as zero
	`SFR_CHECK_IMPLY(a_depth_zero, out_valid && !depth_valid, depth == '0, "invalid depth not zero")
	// once a result is shown, the error count never goes down
	`SFR_CHECK_NEXT(a_err_mono, out_valid, error_count >= $past(error_count), "error count decreased")

endmodule

// File: design/sfr_useq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on sfr_pkg.
module sfr_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sfr_pkg::dp_flags_t flags,
	output sfr_pkg::dp_ctl_t   ctl
);

	sfr_pkg::step_t  step_q, step_d;
	sfr_pkg::uword_t uw;
	logic [sfr_pkg::STEP_W-1:0] step_inc;
	logic go, hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sfr_pkg::ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	assign step_inc = step_q + 1'b1;

	always_comb begin
		uw = sfr_pkg::ucode(step_q);
		// hold the step until its input or output side is ready
		go = (!uw.wait_in || in_valid) && (!uw.wait_out || flags.out_free);
		case (uw.cond)
			sfr_pkg::C_NEVER:    hit = 1'b0;
			sfr_pkg::C_ALWAYS:   hit = 1'b1;
			sfr_pkg::C_START:    hit = flags.start;
			sfr_pkg::C_NOSYNC:   hit = !flags.synced;
			sfr_pkg::C_POS_FULL: hit = flags.pos_full;
			sfr_pkg::C_SUM_OK:   hit = flags.sum_ok;
			sfr_pkg::C_MORE:     hit = flags.more;
			default:             hit = 1'b0;
		endcase
		step_d = step_q;
		if (go) begin
			step_d = hit ? uw.target : sfr_pkg::step_t'(step_inc);
		end
		in_stall = !uw.wait_in;
		ctl.op   = uw.op;
		ctl.fire = go;
	end

endmodule

// File: design/sfr_datapath.sv
// Datapath: frame registers, slot store, checksum and the output register.
// Depends on sfr_pkg; driven by the control word from sfr_useq.
module sfr_datapath #(
	parameter int N_SLOTS = sfr_pkg::N_SLOTS_DEF,
	parameter int SLOT_W  = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfr_pkg::dp_ctl_t            ctl,
	output sfr_pkg::dp_flags_t          flags,
	input  logic [sfr_pkg::WORD_W-1:0]  link_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sfr_pkg::STAT_W-1:0]  status,
	output logic [SLOT_W-1:0]           slot,
	output logic [sfr_pkg::DUTY_W-1:0]  duty,
	output logic [sfr_pkg::DEPTH_W-1:0] depth,
	output logic                        depth_valid,
	output logic [sfr_pkg::ERR_W-1:0]   error_count,
	output logic                        last
);

	localparam int POS_W = (N_SLOTS > 1) ? $clog2(N_SLOTS + 1) : 1;

	logic [sfr_pkg::WORD_W-1:0] word_q;
	logic [POS_W-1:0]           pos_q;
	logic [sfr_pkg::WORD_W-1:0] sum_q;
	logic                       synced_q;
	logic [sfr_pkg::PEND_W-1:0] pend_q;
	logic [sfr_pkg::ERR_W-1:0]  errors_q;
	logic [SLOT_W-1:0]          idx_q, idx_d;
	logic [sfr_pkg::DUTY_W-1:0] store_mem [N_SLOTS];
	logic [sfr_pkg::DUTY_W-1:0] rd_q;
	logic                       out_valid_q;
	logic [sfr_pkg::STAT_W-1:0] status_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [sfr_pkg::DUTY_W-1:0] duty_q;
	logic [sfr_pkg::DEPTH_W-1:0] depth_q;
	logic                       dvalid_q;
	logic [sfr_pkg::ERR_W-1:0]  errcnt_q;
	logic                       last_q;

	logic [sfr_pkg::ERR_W-1:0]  err_inc;
	logic                       dv;
	logic                       is_last;
	logic                       load_out;
	logic                       out_free;

	assign err_inc  = (errors_q == '1) ? errors_q : errors_q + 1'b1;
	assign dv       = (pend_q <= sfr_pkg::MAX_DEPTH);
	assign is_last  = (idx_q == SLOT_W'(N_SLOTS - 1));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		load_out = ctl.fire && (ctl.op inside {sfr_pkg::OP_ERR_SYNC, sfr_pkg::OP_ERR_SUM,
			sfr_pkg::OP_SLOT});
		idx_d = idx_q;
		if (ctl.fire && ctl.op == sfr_pkg::OP_FRAME_END) begin
			idx_d = '0;
		end else if (ctl.fire && ctl.op == sfr_pkg::OP_SLOT && !is_last) begin
			idx_d = idx_q + 1'b1;
		end
		flags.start    = word_q[sfr_pkg::START_BIT];
		flags.synced   = synced_q;
		flags.pos_full = (pos_q == POS_W'(N_SLOTS));
		flags.sum_ok   = ({1'b0, sum_q[sfr_pkg::DUTY_W-1:0]} == word_q);
		flags.more     = !is_last;
		flags.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			synced_q    <= 1'b0;
			pend_q      <= '0;
			errors_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.fire) begin
				case (ctl.op)
					sfr_pkg::OP_STORE: begin
						pos_q <= pos_q + 1'b1;
						sum_q <= sum_q + word_q;
					end
					sfr_pkg::OP_START: begin
						pos_q    <= '0;
						sum_q    <= '0;
						synced_q <= 1'b1;
						pend_q   <= word_q[sfr_pkg::PEND_W-1:0];
					end
					sfr_pkg::OP_ERR_SYNC: errors_q <= err_inc;
					sfr_pkg::OP_ERR_SUM: begin
						errors_q <= err_inc;
						pos_q    <= '0;
						sum_q    <= '0;
					end
					sfr_pkg::OP_FRAME_END: begin
						pos_q    <= '0;
						sum_q    <= '0;
						synced_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers and slot store
	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.op == sfr_pkg::OP_LATCH) begin
			word_q <= link_word;
		end
		if (ctl.fire && ctl.op == sfr_pkg::OP_STORE) begin
			store_mem[pos_q[SLOT_W-1:0]] <= word_q[sfr_pkg::DUTY_W-1:0];
		end
		rd_q <= store_mem[idx_d];
		if (load_out) begin
			if (ctl.op == sfr_pkg::OP_SLOT) begin
				status_q <= sfr_pkg::STAT_SLOT;
				slot_q   <= idx_q;
				duty_q   <= rd_q;
				depth_q  <= dv ? pend_q[sfr_pkg::DEPTH_W-1:0] : '0;
				dvalid_q <= dv;
				errcnt_q <= errors_q;
				last_q   <= is_last;
			end else begin
				status_q <= (ctl.op == sfr_pkg::OP_ERR_SYNC) ? sfr_pkg::STAT_NOSYNC
					: sfr_pkg::STAT_MISMATCH;
				slot_q   <= '0;
				duty_q   <= '0;
				depth_q  <= '0;
				dvalid_q <= 1'b0;
				errcnt_q <= err_inc;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign duty        = duty_q;
	assign depth       = depth_q;
	assign depth_valid = dvalid_q;
	assign error_count = errcnt_q;
	assign last        = last_q;

endmodule

// File: sim/sync_frame_receiver_tb.sv
// Self-checking testbench for the sync frame receiver: directed table, then random frames.
// Depends on sfr_pkg and the sync_frame_receiver RTL; needs no other file.
`timescale 1ns / 1ps

module sync_frame_receiver_tb;

	localparam int NUM_SLOTS = sfr_pkg::N_SLOTS_DEF;
	localparam int RAND_WORDS = 110;
	// Worst-case busy time of one transaction (checksum match), with margin.
	localparam int SETTLE = 6 + NUM_SLOTS + 1 + 30;
	localparam int MAX_ERRS = 16'hFFFF;

	// One output transaction, field by field.
	typedef struct packed {
		sfr_pkg::status_t            status;
		logic [2:0]                  slot;
		logic [sfr_pkg::DUTY_W-1:0]  duty;
		logic [sfr_pkg::DEPTH_W-1:0] depth;
		logic                        depth_valid;
		logic [sfr_pkg::ERR_W-1:0]   errs;
		logic                        last;
	} frame_result_t;

	// How a row of the directed table is checked.
	typedef enum logic [1:0] {
		ROW_PRED, // checked against the predictor
		ROW_NONE, // typed: causes no result
		ROW_ERR   // typed: one error result
	} row_kind_t;

	typedef struct packed {
		logic [sfr_pkg::WORD_W-1:0] word;
		row_kind_t                  kind;
		sfr_pkg::status_t           ex_status;
		logic [sfr_pkg::ERR_W-1:0]  ex_errs;
	} plan_row_t;

	localparam int PLAN_LEN = 27;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [sfr_pkg::WORD_W-1:0]   link_word;
	logic                         out_valid;
	logic                         out_stall;
	logic [sfr_pkg::STAT_W-1:0]   status;
	logic [2:0]                   slot;
	logic [sfr_pkg::DUTY_W-1:0]   duty;
	logic [sfr_pkg::DEPTH_W-1:0]  depth;
	logic                         depth_valid;
	logic [sfr_pkg::ERR_W-1:0]    error_count;
	logic                         last;

	// Predictor state: a private copy of the receiver.
	int                           frame_pos;
	logic [sfr_pkg::WORD_W-1:0]   frame_sum;
	logic                         in_sync;
	logic [sfr_pkg::PEND_W-1:0]   held_depth;
	logic [sfr_pkg::DUTY_W-1:0]   duty_store [NUM_SLOTS];
	logic [sfr_pkg::ERR_W-1:0]    err_total;

	frame_result_t       pending_results [$];
	plan_row_t           plan [PLAN_LEN];

	int unsigned         words_sent;
	int unsigned         fail_count;
	int unsigned         n_frames;
	int unsigned         n_mismatch;
	int unsigned         n_nosync;
	int unsigned         n_results;
	bit                  src_pace;
	bit                  sink_pace;
	bit                  sink_hold;
	int unsigned         sink_left;
	bit                  drained_once;

	sync_frame_receiver #(.N_SLOTS(NUM_SLOTS)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.link_word   (link_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot        (slot),
		.duty        (duty),
		.depth       (depth),
		.depth_valid (depth_valid),
		.error_count (error_count),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly short, now and then a long one.
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(15, 50);
		return $urandom_range(1, 3);
	endfunction

	// Advance the receiver copy by one accepted word; queue its results when asked.
	task automatic predict_word(input logic [sfr_pkg::WORD_W-1:0] w, input bit keep);
		frame_result_t r;
		bit            dv;
		r = '{status: sfr_pkg::STAT_NOSYNC, slot: '0, duty: '0, depth: '0,
			depth_valid: 1'b0, errs: '0, last: 1'b1};
		if (w[sfr_pkg::START_BIT]) begin
			// Start word: restart the frame, keep the depth byte, no result.
			frame_pos  = 0;
			frame_sum  = '0;
			in_sync    = 1'b1;
			held_depth = w[sfr_pkg::PEND_W-1:0];
			return;
		end
		if (!in_sync) begin
			if (err_total != MAX_ERRS)
				err_total++;
			n_nosync++;
			r.errs = err_total;
			if (keep)
				pending_results.push_back(r);
			return;
		end
		frame_pos++;
		if (frame_pos == NUM_SLOTS + 1) begin
			if (frame_sum[sfr_pkg::DUTY_W-1:0] == w[sfr_pkg::DUTY_W-1:0]) begin
				dv = (held_depth <= sfr_pkg::MAX_DEPTH);
				for (int i = 0; i < NUM_SLOTS; i++) begin
					r.status      = sfr_pkg::STAT_SLOT;
					r.slot        = 3'(i);
					r.duty        = duty_store[i];
					r.depth       = dv ? held_depth[sfr_pkg::DEPTH_W-1:0] : '0;
					r.depth_valid = dv;
					r.errs        = err_total;
					r.last        = (i == NUM_SLOTS - 1);
					if (keep)
						pending_results.push_back(r);
				end
				in_sync = 1'b0;
				n_frames++;
			end else begin
				// Mismatch: stay synchronized, report one error.
				if (err_total != MAX_ERRS)
					err_total++;
				n_mismatch++;
				r.status = sfr_pkg::STAT_MISMATCH;
				r.errs   = err_total;
				if (keep)
					pending_results.push_back(r);
			end
			frame_pos = 0;
			frame_sum = '0;
			return;
		end
		duty_store[frame_pos - 1] = w[sfr_pkg::DUTY_W-1:0];
		frame_sum = frame_sum + w;
	endtask

	// Offer one word, hold it until accepted, then update the prediction.
	task automatic send_word(input logic [sfr_pkg::WORD_W-1:0] w, input bit keep);
		int unsigned gap;
		gap = (src_pace && $urandom_range(0, 1)) ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		link_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		predict_word(w, keep);
	endtask

	// Start word, a full set of slots, then a right or wrong checksum.
	task automatic send_frame(input bit good);
		logic [sfr_pkg::WORD_W-1:0] sum;
		logic [sfr_pkg::DUTY_W-1:0] d;
		logic [sfr_pkg::DUTY_W-1:0] flip;
		sum = '0;
		send_word({1'b1, 7'($urandom),
			($urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom))}, 1'b1);
		for (int k = 0; k < NUM_SLOTS; k++) begin
			case ($urandom_range(0, 7))
				0: d = '0;
				1: d = '1;
				default: d = sfr_pkg::DUTY_W'($urandom);
			endcase
			send_word({1'b0, d}, 1'b1);
			sum = sum + {1'b0, d};
		end
		flip = good ? '0 : (sfr_pkg::DUTY_W'($urandom) | 15'd1);
		send_word({1'b0, sum[sfr_pkg::DUTY_W-1:0] ^ flip}, 1'b1);
	endtask

	// Hold the sender until every queued result is out, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Sink: alternate ready runs and stall runs while pacing is on.
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_hold = sink_pace && !sink_hold;
			sink_left = sink_hold ? pick_gap() : $urandom_range(1, 12);
		end
		sink_left--;
		out_stall <= sink_hold;
	end

	// Scoreboard: compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("[%0t] unexpected result: status=%0d slot=%0d duty=%h errs=%0d",
						$realtime, status, slot, duty, error_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || slot !== want.slot || duty !== want.duty ||
					depth !== want.depth || depth_valid !== want.depth_valid ||
					error_count !== want.errs || last !== want.last) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("[%0t] mismatch exp: status=%0d slot=%0d duty=%h depth=%0d dv=%b errs=%0d last=%b",
							$realtime, want.status, want.slot, want.duty, want.depth,
							want.depth_valid, want.errs, want.last);
						$display("[%0t]          got: status=%0d slot=%0d duty=%h depth=%0d dv=%b errs=%0d last=%b",
							$realtime, status, slot, duty, depth, depth_valid,
							error_count, last);
					end
				end
			end
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		in_valid   <= 1'b0;
		link_word  <= '0;
		out_stall  <= 1'b0;
		arst_n     <= 1'b0;
		frame_pos  = 0;
		frame_sum  = '0;
		in_sync    = 1'b0;
		held_depth = '0;
		err_total  = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			duty_store[i] = '0;
		words_sent     = 0;
		fail_count     = 0;
		n_frames       = 0;
		n_mismatch     = 0;
		n_nosync       = 0;
		n_results      = 0;
		src_pace       = 1'b1;
		sink_pace      = 1'b1;
		sink_hold      = 1'b0;
		sink_left      = 0;
		drained_once   = 1'b0;

		// Directed table: words before sync, full-range data, mid-frame
		// restart, checksum mismatch while synchronized, depth 15 and above.
		plan = '{
			'{16'h0000, ROW_ERR,  sfr_pkg::STAT_NOSYNC,   16'd1},
			'{16'h7FFF, ROW_ERR,  sfr_pkg::STAT_NOSYNC,   16'd2},
			'{16'hFFFF, ROW_NONE, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h7FFF, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0000, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h7FFF, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0001, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h1234, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0ABC, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h1CEF, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h8010, ROW_NONE, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0005, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h800F, ROW_NONE, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0001, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0002, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0003, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0004, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0005, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0006, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0016, ROW_ERR,  sfr_pkg::STAT_MISMATCH, 16'd3},
			'{16'h0001, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0002, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0003, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0004, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0005, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0006, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0},
			'{16'h0015, ROW_PRED, sfr_pkg::STAT_SLOT,     16'd0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table; typed rows replace the prediction with their own value.
		for (int i = 0; i < PLAN_LEN; i++) begin
			send_word(plan[i].word, plan[i].kind == ROW_PRED);
			if (plan[i].kind == ROW_ERR)
				pending_results.push_back(frame_result_t'{status: plan[i].ex_status,
					slot: '0, duty: '0, depth: '0, depth_valid: 1'b0,
					errs: plan[i].ex_errs, last: 1'b1});
		end

		// Random part: mostly well-formed frames, plus noise and broken frames.
		while (words_sent < PLAN_LEN + RAND_WORDS) begin
			if ($urandom_range(0, 5) == 0)
				src_pace = $urandom_range(0, 1);
			if ($urandom_range(0, 5) == 0)
				sink_pace = $urandom_range(0, 1);
			if (!drained_once && words_sent >= PLAN_LEN + RAND_WORDS / 2) begin
				wait_idle();
				drained_once = 1'b1;
			end
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 3))
					send_word(16'($urandom), 1'b1);
				1: begin
					// Abandon a frame partway; the next start word restarts it.
					send_word({1'b1, 15'($urandom)}, 1'b1);
					repeat ($urandom_range(0, NUM_SLOTS - 1))
						send_word({1'b0, 15'($urandom)}, 1'b1);
				end
				2: repeat ($urandom_range(1, 3))
					send_word({1'b0, 15'($urandom)}, 1'b1);
				3: send_frame(1'b0);
				default: send_frame(1'b1);
			endcase
		end

		// Closing frames, flat out on both sides.
		wait_idle();
		src_pace  = 1'b0;
		sink_pace = 1'b0;
		send_frame(1'b0);
		send_frame(1'b1);

		wait_idle();

		$display("Ran %0d link words, %0d results: %0d frames delivered, %0d bad checksums,",
			words_sent, n_results, n_frames, n_mismatch);
		$display("%0d words before sync; final error count %0d.", n_nosync, err_total);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/sfr_pkg.sv
design/sfr_useq.sv
design/sfr_datapath.sv
design/sync_frame_receiver.sv
sim/sync_frame_receiver_tb.sv
